[src/aopi_pkg.sv]
// Shared types, constants and the arctangent table for the arc odometry pose integrator.
package aopi_pkg;

  localparam int VW = 34;

  localparam logic signed [25:0] DEG_TO_RAD_Q30 = 26'sd18740330;
  localparam logic signed [34:0] HALF_PI_Q30    = 35'sh06487ED51;
  localparam logic signed [34:0] PI_Q30         = 35'sh0C90FDAA2;
  localparam logic signed [34:0] TWO_PI_Q30     = 35'sh1921FB544;
  localparam logic signed [VW-1:0] GAIN_Q30     = 34'sh26DD3B6A;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAD,
    ST_DELTA,
    ST_HALF_WAIT,
    ST_HALF_S,
    ST_DIV_WAIT,
    ST_CHORD,
    ST_MID_WAIT,
    ST_MID_S,
    ST_MID_C,
    ST_ACC_X,
    ST_ACC_Y,
    ST_OUT
  } aopi_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_REDUCE,
    CS_FOLD,
    CS_ITER
  } aopi_cstate_t;

  typedef enum logic {
    DS_IDLE,
    DS_RUN
  } aopi_dstate_t;

  typedef struct packed {
    logic                 done;
    logic                 neg;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] r;
  } aopi_cordic_res_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q;
  } aopi_div_res_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

[src/aopi_if.sv]
// Valid/ready channel interfaces for odometry ticks and pose results.
interface aopi_tick_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_distance;
  logic signed [31:0] right_distance;
  logic signed [31:0] heading_degrees;

  modport source (output valid, output left_distance, output right_distance,
                  output heading_degrees, input ready);
  modport sink (input valid, input left_distance, input right_distance,
                input heading_degrees, output ready);
endinterface

interface aopi_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_theta;

  modport source (output valid, output pose_x, output pose_y, output pose_theta,
                  input ready);
  modport sink (input valid, input pose_x, input pose_y, input pose_theta,
                output ready);
endinterface

[src/aopi_cordic.sv]
// Iterative angle reduction, quadrant fold and CORDIC rotation unit.
module aopi_cordic #(
  parameter int AW    = 46,
  parameter int STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [AW-1:0]       angle,
  output aopi_pkg::aopi_cordic_res_t res
);

  localparam int VW   = aopi_pkg::VW;
  localparam int KMAX = AW - 33;
  localparam int KW   = $clog2(KMAX + 1);
  localparam int IW   = $clog2(STEPS);
  localparam logic [AW:0] TP_BASE = (AW + 1)'(aopi_pkg::TWO_PI_Q30);

  aopi_pkg::aopi_cstate_t state, state_next;

  logic [AW-1:0]        mag;
  logic                 sgn;
  logic [KW-1:0]        kcnt;
  logic [IW-1:0]        icnt;
  logic signed [VW-1:0] x, y, r;
  logic                 neg;
  logic                 done;

  logic [AW:0]          tp_sh;
  logic                 tp_ge;
  logic [32:0]          m;
  logic signed [34:0]   r_a, r_b, r_c;
  logic                 fold_neg;
  logic signed [VW-1:0] xs, ys, at;
  logic                 last_iter;

  always_comb begin
    tp_sh = TP_BASE << kcnt;
    tp_ge = {1'b0, mag} >= tp_sh;
    m     = mag[32:0];
    r_a   = (sgn && (m != '0)) ? aopi_pkg::TWO_PI_Q30 - $signed({2'b00, m})
                               : $signed({2'b00, m});
    r_b   = (r_a > aopi_pkg::PI_Q30) ? r_a - aopi_pkg::TWO_PI_Q30 : r_a;
    fold_neg = 1'b0;
    r_c   = r_b;
    if (r_b > aopi_pkg::HALF_PI_Q30) begin
      r_c = r_b - aopi_pkg::PI_Q30;
      fold_neg = 1'b1;
    end else if (r_b < -aopi_pkg::HALF_PI_Q30) begin
      r_c = r_b + aopi_pkg::PI_Q30;
      fold_neg = 1'b1;
    end
    xs = x >>> icnt;
    ys = y >>> icnt;
    at = $signed({4'b0000, aopi_pkg::atan_q30(5'(icnt))});
    last_iter = (icnt == IW'(STEPS - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aopi_pkg::CS_IDLE:   if (start) state_next = aopi_pkg::CS_REDUCE;
      aopi_pkg::CS_REDUCE: if (kcnt == '0) state_next = aopi_pkg::CS_FOLD;
      aopi_pkg::CS_FOLD:   state_next = aopi_pkg::CS_ITER;
      aopi_pkg::CS_ITER:   if (last_iter) state_next = aopi_pkg::CS_IDLE;
      default:             state_next = aopi_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aopi_pkg::CS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == aopi_pkg::CS_ITER) && last_iter;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      aopi_pkg::CS_IDLE: begin
        if (start) begin
          sgn  <= angle[AW-1];
          mag  <= angle[AW-1] ? AW'(-angle) : AW'(angle);
          kcnt <= KW'(KMAX);
        end
      end
      aopi_pkg::CS_REDUCE: begin
        if (tp_ge) mag <= AW'({1'b0, mag} - tp_sh);
        kcnt <= kcnt - 1'b1;
      end
      aopi_pkg::CS_FOLD: begin
        r    <= VW'(r_c);
        neg  <= fold_neg;
        x    <= aopi_pkg::GAIN_Q30;
        y    <= '0;
        icnt <= '0;
      end
      aopi_pkg::CS_ITER: begin
        if (!r[VW-1]) begin
          x <= x - ys;
          y <= y + xs;
          r <= r - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          r <= r + at;
        end
        icnt <= icnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign res.done = done;
  assign res.neg  = neg;
  assign res.x    = x;
  assign res.y    = y;
  assign res.r    = r;

endmodule

[src/aopi_div.sv]
// Restoring divider for the chord factor, one quotient bit per cycle, clamped to one.
module aopi_div #(
  parameter int DW = 47
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [aopi_pkg::VW-1:0]     s,
  input  logic signed [DW-1:0]               den,
  output aopi_pkg::aopi_div_res_t            res
);

  localparam int VW = aopi_pkg::VW;
  localparam int QB = 31;
  localparam int RW = ((VW > DW) ? VW : DW) + QB + 1;
  localparam logic [QB-1:0] ONE_Q30 = QB'(1) << 30;

  aopi_pkg::aopi_dstate_t state, state_next;

  logic [RW-1:0]      rem, dsh;
  logic [4:0]         cnt;
  logic [QB-1:0]      qm;
  logic               ovf, sgn, done;
  logic signed [31:0] q;

  logic               ge;
  logic [QB-1:0]      qn, qmag;
  logic [VW-1:0]      s_mag;
  logic [DW-1:0]      d_mag;

  always_comb begin
    s_mag = s[VW-1] ? VW'(-s) : VW'(s);
    d_mag = den[DW-1] ? DW'(-den) : DW'(den);
    ge    = rem >= dsh;
    qn    = {qm[QB-2:0], ge};
    qmag  = (ovf || (qn > ONE_Q30)) ? ONE_Q30 : qn;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aopi_pkg::DS_IDLE: if (start) state_next = aopi_pkg::DS_RUN;
      aopi_pkg::DS_RUN:  if (cnt == '0) state_next = aopi_pkg::DS_IDLE;
      default:           state_next = aopi_pkg::DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aopi_pkg::DS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == aopi_pkg::DS_RUN) && (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      aopi_pkg::DS_IDLE: begin
        if (start) begin
          rem <= RW'({s_mag, {QB{1'b0}}});
          dsh <= RW'({d_mag, {QB{1'b0}}});
          cnt <= 5'(QB);
          qm  <= '0;
          ovf <= 1'b0;
          sgn <= s[VW-1] ^ den[DW-1];
        end
      end
      aopi_pkg::DS_RUN: begin
        if (cnt == 5'(QB)) begin
          ovf <= ge;
        end else begin
          if (ge) rem <= rem - dsh;
          qm <= qn;
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) q <= sgn ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      end
      default: ;
    endcase
  end

  assign res.done = done;
  assign res.q    = q;

endmodule

[src/arc_odometry_pose_integrator.sv]
// Arc odometry pose integrator: sequencer, shared multiplier and pose accumulators.
// A tick with a heading change runs two CORDIC passes (angle reduction plus rotation)
// and the divider between accept and pose valid; a tick with no heading change skips
// the half-angle pass and the divider. A new tick is accepted only in the idle step,
// after the previous pose has been handed to the output register.
// A waiting pose beat holds the sequencer in its output step until the beat is taken.
// Synchronous reset clears the pose accumulators, the previous distance and heading, and all control.
module arc_odometry_pose_integrator #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  aopi_tick_if.sink          tick,
  aopi_pose_if.source        pose
);

  localparam int VW = aopi_pkg::VW;
  localparam int PW = 2 * VW;
  localparam int QS = 30 - FRACTION_BITS;
  localparam int AW = 32 + QS;
  localparam int DW = 33 + QS;
  localparam logic signed [PW-1:0] RND = PW'(64'sd536870912);

  aopi_pkg::aopi_state_t state, state_next;

  logic signed [31:0]   last_distance, last_heading;
  logic signed [31:0]   acc_x, acc_y, acc_theta;
  logic signed [31:0]   avg, rad;
  logic signed [32:0]   dv, dh, hsum;
  logic signed [VW-1:0] s_val, chord;
  logic signed [PW-1:0] prod;
  logic signed [31:0]   out_x, out_y, out_theta;
  logic                 out_valid;

  logic signed [VW-1:0] mul_a, mul_b;
  logic signed [PW-31:0] prod_sh;
  logic signed [PW-1:0] rad_sum;
  logic signed [32:0]   sum_lr, dv_c, dh_c, hsum_c;
  logic signed [VW-1:0] p_lo, s_c, c_c;
  logic                 cord_start, div_start, out_free;
  logic signed [AW-1:0] cord_angle;
  logic signed [DW-1:0] div_den;

  aopi_pkg::aopi_cordic_res_t cres;
  aopi_pkg::aopi_div_res_t    dres;

  function automatic logic signed [31:0] sat32(input logic signed [PW-30:0] v);
    if (v > PW'(33'sh07FFFFFFF)) return 32'sh7FFFFFFF;
    if (v < -PW'(33'sh080000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  aopi_cordic #(.AW(AW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (cord_angle),
    .res   (cres)
  );

  aopi_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .s     (s_c),
    .den   (div_den),
    .res   (dres)
  );

  always_comb begin
    sum_lr  = 33'(tick.left_distance) + 33'(tick.right_distance);
    prod_sh = prod[PW-1:30];
    rad_sum = prod + RND;
    dv_c    = 33'(avg) - 33'(last_distance);
    dh_c    = 33'(rad) - 33'(last_heading);
    hsum_c  = 33'(last_heading) + 33'(rad);
    p_lo    = VW'(prod_sh);
    s_c     = cres.neg ? -(cres.y + p_lo) : (cres.y + p_lo);
    c_c     = cres.neg ? -(cres.x - p_lo) : (cres.x - p_lo);
    div_den = {dh, {QS{1'b0}}};
    out_free = !out_valid || pose.ready;
  end

  always_comb begin
    state_next = state;
    mul_a      = cres.x;
    mul_b      = cres.r;
    cord_start = 1'b0;
    cord_angle = {hsum, {(QS - 1){1'b0}}};
    div_start  = 1'b0;
    unique case (state)
      aopi_pkg::ST_IDLE: begin
        mul_a = VW'(tick.heading_degrees);
        mul_b = VW'(aopi_pkg::DEG_TO_RAD_Q30);
        if (tick.valid) state_next = aopi_pkg::ST_RAD;
      end
      aopi_pkg::ST_RAD: state_next = aopi_pkg::ST_DELTA;
      aopi_pkg::ST_DELTA: begin
        cord_start = 1'b1;
        if (dh_c == '0) begin
          cord_angle = {hsum_c, {(QS - 1){1'b0}}};
          state_next = aopi_pkg::ST_MID_WAIT;
        end else begin
          cord_angle = {dh_c, {(QS - 1){1'b0}}};
          state_next = aopi_pkg::ST_HALF_WAIT;
        end
      end
      aopi_pkg::ST_HALF_WAIT: if (cres.done) state_next = aopi_pkg::ST_HALF_S;
      aopi_pkg::ST_HALF_S: begin
        div_start  = 1'b1;
        state_next = aopi_pkg::ST_DIV_WAIT;
      end
      aopi_pkg::ST_DIV_WAIT: begin
        mul_a = VW'(dv);
        mul_b = VW'(dres.q);
        if (dres.done) state_next = aopi_pkg::ST_CHORD;
      end
      aopi_pkg::ST_CHORD: begin
        cord_start = 1'b1;
        state_next = aopi_pkg::ST_MID_WAIT;
      end
      aopi_pkg::ST_MID_WAIT: if (cres.done) state_next = aopi_pkg::ST_MID_S;
      aopi_pkg::ST_MID_S: begin
        mul_a      = cres.y;
        state_next = aopi_pkg::ST_MID_C;
      end
      aopi_pkg::ST_MID_C: begin
        mul_a      = chord;
        mul_b      = c_c;
        state_next = aopi_pkg::ST_ACC_X;
      end
      aopi_pkg::ST_ACC_X: begin
        mul_a      = chord;
        mul_b      = s_val;
        state_next = aopi_pkg::ST_ACC_Y;
      end
      aopi_pkg::ST_ACC_Y: state_next = aopi_pkg::ST_OUT;
      aopi_pkg::ST_OUT: if (out_free) state_next = aopi_pkg::ST_IDLE;
      default: state_next = aopi_pkg::ST_IDLE;
    endcase
  end

  assign tick.ready = (state == aopi_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= aopi_pkg::ST_IDLE;
      last_distance <= '0;
      last_heading  <= '0;
      acc_x         <= '0;
      acc_y         <= '0;
      acc_theta     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        aopi_pkg::ST_IDLE:   if (tick.valid) avg <= sum_lr[32:1];
        aopi_pkg::ST_RAD:    rad <= rad_sum[61:30];
        aopi_pkg::ST_DELTA: begin
          dv   <= dv_c;
          dh   <= dh_c;
          hsum <= hsum_c;
          if (dh_c == '0) chord <= VW'(dv_c);
        end
        aopi_pkg::ST_CHORD:  chord <= VW'(prod_sh);
        aopi_pkg::ST_MID_S:  s_val <= s_c;
        aopi_pkg::ST_ACC_X:  acc_x <= sat32((PW - 29)'(acc_x) + (PW - 29)'(prod_sh));
        aopi_pkg::ST_ACC_Y: begin
          acc_y         <= sat32((PW - 29)'(acc_y) + (PW - 29)'(prod_sh));
          acc_theta     <= hsum[32:1];
          last_distance <= avg;
          last_heading  <= rad;
        end
        default: ;
      endcase
      if ((state == aopi_pkg::ST_OUT) && out_free) begin
        out_valid <= 1'b1;
        out_x     <= acc_x;
        out_y     <= acc_y;
        out_theta <= acc_theta;
      end else if (pose.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pose.valid      = out_valid;
  assign pose.pose_x     = out_x;
  assign pose.pose_y     = out_y;
  assign pose.pose_theta = out_theta;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> state == aopi_pkg::ST_RAD)
    else $error("accepted tick did not start the sequence");

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cres.done |-> state == aopi_pkg::ST_HALF_WAIT || state == aopi_pkg::ST_MID_WAIT)
    else $error("cordic finished outside a wait state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dres.done |-> state == aopi_pkg::ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_theta_hold: assert property (@(posedge clk) disable iff (rst)
    state != aopi_pkg::ST_ACC_Y |=> $stable(acc_theta))
    else $error("heading accumulator changed outside its update step");

endmodule
